// File: src/cec_pkg.sv
// shared types, constants and tag text functions for the backtick color code expander
`default_nettype none
package cec_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] TICK_CHAR = 8'h60;

  localparam logic [103:0] COLOR_PFX = "<font color=\"";
  localparam logic [95:0]  SIZE_PFX  = "<font size=\"";
  localparam logic [23:0]  PCT_TXT   = "%3D";

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_text;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_BYTE,
    CMD_PCT,
    CMD_COLOR,
    CMD_SIZE,
    CMD_EMPTY
  } cmd_kind_e;

  // arg: plain byte, color index, or {two_digit, 0, tens[1:0], ones[3:0]}
  typedef struct packed {
    cmd_kind_e  kind;
    logic       last;
    logic [7:0] arg;
  } cmd_t;

  function automatic logic [23:0] color_rgb(logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = 24'h0000A8;
      4'd1:    rgb = 24'h007000;
      4'd2:    rgb = 24'h008080;
      4'd3:    rgb = 24'hFF0000;
      4'd4:    rgb = 24'hCC66CC;
      4'd5:    rgb = 24'hA85400;
      4'd6:    rgb = 24'h808080;
      4'd7:    rgb = 24'h505050;
      4'd8:    rgb = 24'h5454FC;
      4'd9:    rgb = 24'h00B000;
      4'd10:   rgb = 24'h00A0A0;
      4'd11:   rgb = 24'hFC5454;
      4'd12:   rgb = 24'hFC54FC;
      4'd13:   rgb = 24'hFFFF33;
      4'd14:   rgb = 24'hFFFFFF;
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) ch = 8'h30 + {4'b0, nib};
    else ch = 8'h37 + {4'b0, nib};
    return ch;
  endfunction

  // index of the final byte a command expands to
  function automatic logic [4:0] cmd_last_idx(cmd_t c);
    logic [4:0] n;
    case (c.kind)
      CMD_PCT:   n = 5'd2;
      CMD_COLOR: n = 5'd21;
      CMD_SIZE:  n = 5'd14 + {4'b0, c.arg[7]};
      default:   n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] cmd_char(cmd_t c, logic [4:0] idx);
    int          i;
    int          p;
    logic [23:0] rgb;
    logic [7:0]  ch;
    i = int'(idx);
    p = 0;
    rgb = color_rgb(c.arg[3:0]);
    ch = 8'h00;
    case (c.kind)
      CMD_BYTE: ch = c.arg;
      CMD_PCT: begin
        if (i < 3) ch = PCT_TXT[8*(2-i) +: 8];
      end
      CMD_COLOR: begin
        if (i < 13) ch = COLOR_PFX[8*(12-i) +: 8];
        else if (i == 13) ch = "#";
        else if (i < 20) ch = hex_char(rgb[4*(19-i) +: 4]);
        else if (i == 20) ch = "\"";
        else ch = ">";
      end
      CMD_SIZE: begin
        if (i < 12) begin
          ch = SIZE_PFX[8*(11-i) +: 8];
        end else begin
          p = i - 12;
          if (!c.arg[7]) p = p + 1;
          if (p == 0) ch = 8'h30 + {6'b0, c.arg[5:4]};
          else if (p == 1) ch = 8'h30 + {4'b0, c.arg[3:0]};
          else if (p == 2) ch = "\"";
          else ch = ">";
        end
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// File: src/backtick_color_code_expander_top.sv
// top level of the backtick color code expander
`default_nettype none
// Rewrites a byte stream, expanding backtick escapes into HTML font tags or %3D (or
// dropping them when strip_mode is set). Plain bytes flow through at one item per cycle
// while the queue has room. An escape expands to up to 22 result bytes, which the back
// sequencer emits one per cycle unless stalled, from the head of a QueueDepth-entry
// command queue; the input keeps taking items until that queue is full. Results pass
// through the queue, then the output register. Write strip_mode only while idle.
module backtick_color_code_expander_top #(
  parameter int QueueDepth = cec_pkg::QUEUE_DEPTH
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire                cfg_strip_mode_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  cec_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output cec_pkg::out_item_t out_data_o
);
  import cec_pkg::*;

  logic cmd_push;
  cmd_t cmd;
  logic q_full;
  logic head_valid;
  cmd_t head;
  logic pop;

  assign cfg_ready_o = 1'b1;

  cec_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_strip_mode_i (cfg_strip_mode_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_data_i        (in_data_i),
    .q_full_i         (q_full),
    .cmd_push_o       (cmd_push),
    .cmd_o            (cmd)
  );

  cec_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cmd_push),
    .wr_data_i  (cmd),
    .full_o     (q_full),
    .rd_valid_o (head_valid),
    .rd_data_o  (head),
    .rd_pop_i   (pop)
  );

  cec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_push && q_full))
    else $error("command pushed into a full queue");

  a_bare_marker_ends_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.end_of_text)
    else $error("empty item without end of text");

  a_bare_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.out_byte == 8'h00)
    else $error("empty item carries a nonzero byte");

  a_pop_only_with_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("back end popped an empty queue");
`endif

endmodule
`default_nettype wire

// File: src/cec_queue.sv
// short command queue between the front classifier and the back sequencer
`default_nettype none
module cec_queue #(
  parameter int Depth = 2
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              wr_valid_i,
  input  cec_pkg::cmd_t    wr_data_i,
  output logic             full_o,
  output logic             rd_valid_o,
  output cec_pkg::cmd_t    rd_data_o,
  input  wire              rd_pop_i
);
  import cec_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && !full_o;
  assign pop        = rd_pop_i && rd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule
`default_nettype wire

// File: src/cec_front.sv
// front end: takes input items, tracks the escape phase, turns plain bytes and escapes into commands
`default_nettype none
module cec_front (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_valid_i,
  input  wire                cfg_strip_mode_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  cec_pkg::in_item_t  in_data_i,
  input  wire                q_full_i,
  output logic               cmd_push_o,
  output cec_pkg::cmd_t      cmd_o
);
  import cec_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TICK = 2'd1;
  localparam logic [1:0] PH_SIZE = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic       strip_q;
  logic       accept;
  logic       emit;
  logic [7:0] b;
  logic       last;
  logic [4:0] col;
  logic [3:0] digit;
  logic [4:0] size;
  logic [1:0] tens;
  logic [4:0] ones;

  // {hit, color index}
  function automatic logic [4:0] color_lookup(logic [7:0] c);
    logic [4:0] r;
    case (c)
      "1":      r = {1'b1, 4'd0};
      "2":      r = {1'b1, 4'd1};
      "3":      r = {1'b1, 4'd2};
      "4":      r = {1'b1, 4'd3};
      "5":      r = {1'b1, 4'd4};
      "6":      r = {1'b1, 4'd5};
      "7":      r = {1'b1, 4'd6};
      "8":      r = {1'b1, 4'd7};
      "9":      r = {1'b1, 4'd8};
      "0":      r = {1'b1, 4'd9};
      "!":      r = {1'b1, 4'd10};
      "@":      r = {1'b1, 4'd11};
      "#":      r = {1'b1, 4'd12};
      "$", "y": r = {1'b1, 4'd13};
      "w":      r = {1'b1, 4'd14};
      "^":      r = {1'b1, 4'd15};
      default:  r = 5'd0;
    endcase
    return r;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_data_i.in_byte;
  assign last       = in_data_i.last_in;
  assign col        = color_lookup(b);

  // font size is 8 plus twice the digit, split into decimal digits
  always_comb begin
    digit = (b >= "0" && b <= "9") ? b[3:0] - 4'd0 : 4'd0;
    if (b < "0" || b > "9") digit = 4'd0;
    size = 5'd8 + {digit, 1'b0};
    if (size >= 5'd20) tens = 2'd2;
    else if (size >= 5'd10) tens = 2'd1;
    else tens = 2'd0;
    ones = size - ((tens == 2'd2) ? 5'd20 : (tens == 2'd1) ? 5'd10 : 5'd0);
  end

  always_comb begin
    phase_d  = PH_IDLE;
    emit     = 1'b0;
    cmd_o    = '{kind: CMD_BYTE, last: last, arg: b};
    case (phase_q)
      PH_TICK: begin
        if (b == "f" && !last) begin
          phase_d = PH_SIZE;
        end else if (!strip_q) begin
          emit = 1'b1;
          if (b == "=") begin
            cmd_o.kind = CMD_PCT;
          end else if (col[4]) begin
            cmd_o.kind = CMD_COLOR;
            cmd_o.arg  = {4'b0, col[3:0]};
          end else begin
            cmd_o.arg = TICK_CHAR;
          end
        end
      end
      PH_SIZE: begin
        if (!strip_q) begin
          emit       = 1'b1;
          cmd_o.kind = CMD_SIZE;
          cmd_o.arg  = {tens != 2'd0, 1'b0, tens, ones[3:0]};
        end
      end
      default: begin
        if (b == TICK_CHAR) begin
          if (last) begin
            emit = !strip_q;
          end else begin
            phase_d = PH_TICK;
          end
        end else begin
          emit = 1'b1;
        end
      end
    endcase
    if (last) begin
      phase_d = PH_IDLE;
      if (!emit) begin
        cmd_o.kind = CMD_EMPTY;
        cmd_o.arg  = 8'h00;
      end
    end
  end

  // a last byte always yields a command, even if only an end marker
  assign cmd_push_o = accept && (emit || last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      strip_q <= 1'b0;
    end else begin
      if (accept) phase_q <= phase_d;
      if (cfg_valid_i) strip_q <= cfg_strip_mode_i;
    end
  end

endmodule
`default_nettype wire

// File: src/cec_back.sv
// back end: walks each queued command and emits its bytes into the output register
`default_nettype none
module cec_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                head_valid_i,
  input  cec_pkg::cmd_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output cec_pkg::out_item_t out_data_o
);
  import cec_pkg::*;

  logic [4:0] idx_q, idx_d;
  logic       out_valid_q;
  out_item_t  out_q;
  logic       advance;
  logic       go;
  logic       at_end;
  logic       empty_cmd;

  assign advance   = !out_valid_q || out_ready_i;
  assign go        = advance && head_valid_i;
  assign at_end    = (idx_q == cmd_last_idx(head_i));
  assign pop_o     = go && at_end;
  assign empty_cmd = (head_i.kind == CMD_EMPTY);

  always_comb begin
    idx_d = idx_q;
    if (go) idx_d = at_end ? 5'd0 : idx_q + 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (go) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      out_q.out_byte    <= empty_cmd ? 8'h00 : cmd_char(head_i, idx_q);
      out_q.byte_valid  <= !empty_cmd;
      out_q.end_of_text <= head_i.last && at_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: tb/tb.sv
// testbench for the backtick color code expander: self-checking scoreboard and stimulus
`timescale 1ns / 100ps

import cec_pkg::*;

typedef enum logic [1:0] {
  ESC_IDLE,
  ESC_TICK,
  ESC_SIZE
} esc_phase_e;

class cec_scoreboard;
  out_item_t  expected_q[$];
  bit         strip;
  esc_phase_e phase;
  int         errors;

  function new();
    strip = 1'b0;
    phase = ESC_IDLE;
    errors = 0;
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("mismatch: %s", msg);
  endtask

  function void push_byte(logic [7:0] b);
    out_item_t it;
    it.out_byte = b;
    it.byte_valid = 1'b1;
    it.end_of_text = 1'b0;
    expected_q.push_back(it);
  endfunction

  function void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function string tint_of(logic [7:0] c);
    case (c)
      "1":      return "#0000A8";
      "2":      return "#007000";
      "3":      return "#008080";
      "4":      return "#FF0000";
      "5":      return "#CC66CC";
      "6":      return "#A85400";
      "7":      return "#808080";
      "8":      return "#505050";
      "9":      return "#5454FC";
      "0":      return "#00B000";
      "!":      return "#00A0A0";
      "@":      return "#FC5454";
      "#":      return "#FC54FC";
      "$", "y": return "#FFFF33";
      "w":      return "#FFFFFF";
      "^":      return "#000000";
      default:  return "";
    endcase
  endfunction

  // work out every byte one accepted item produces
  function void note_input(in_item_t it);
    int        first;
    int        digit;
    int        size;
    string     tint;
    logic [7:0] b;
    bit        last;
    out_item_t tail;
    first = expected_q.size();
    b = it.in_byte;
    last = it.last_in;
    case (phase)
      ESC_TICK: begin
        phase = ESC_IDLE;
        if (b == "f" && !last) begin
          phase = ESC_SIZE;
        end else if (!strip) begin
          tint = tint_of(b);
          if (b == "=") begin
            push_text("%3D");
          end else if (tint.len() != 0) begin
            push_text("<font color=\"");
            push_text(tint);
            push_text("\">");
          end else begin
            push_byte(TICK_CHAR);
          end
        end
      end
      ESC_SIZE: begin
        phase = ESC_IDLE;
        if (!strip) begin
          digit = (b >= "0" && b <= "9") ? int'(b) - 48 : 0;
          size = 8 + 2 * digit;
          push_text("<font size=\"");
          if (size >= 10) push_byte(8'(48 + size / 10));
          push_byte(8'(48 + size % 10));
          push_text("\">");
        end
      end
      default: begin
        phase = ESC_IDLE;
        if (b == TICK_CHAR) begin
          if (last) begin
            if (!strip) push_byte(TICK_CHAR);
          end else begin
            phase = ESC_TICK;
          end
        end else begin
          push_byte(b);
        end
      end
    endcase
    if (last) begin
      phase = ESC_IDLE;
      if (expected_q.size() == first) begin
        tail.out_byte = 8'h00;
        tail.byte_valid = 1'b0;
        tail.end_of_text = 1'b1;
      end else begin
        tail = expected_q.pop_back();
        tail.end_of_text = 1'b1;
      end
      expected_q.push_back(tail);
    end
  endfunction

  task check_result(out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("item with no expectation, byte %02h", got.out_byte));
      return;
    end
    want = expected_q.pop_front();
    if (got.out_byte !== want.out_byte)
      report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
    if (got.byte_valid !== want.byte_valid)
      report($sformatf("byte_valid %b, want %b", got.byte_valid, want.byte_valid));
    if (got.end_of_text !== want.end_of_text)
      report($sformatf("end_of_text %b, want %b", got.end_of_text, want.end_of_text));
  endtask
endclass

module tb;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RX_HOLD     = 150;
  localparam int PHASE_ITEMS = 45;
  localparam int SETTLE      = 10;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic      cfg_strip_mode_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  cec_scoreboard sb = new();
  in_item_t      text_q[$];
  string         esc_codes = "1234567890!@#$yw^";
  int            send_idle;
  int            recv_stall;
  bit            hold_rx;
  int            cycles;

  backtick_color_code_expander_top dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_strip_mode_i,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // receiver: random stalls, or a forced hold-off
  always @(negedge clk_i) begin
    out_ready_i = !hold_rx && ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // all tasks in this module are entered and left at a falling edge
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(it);
    @(negedge clk_i);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_item(text_q[i]);
    text_q.delete();
  endtask

  task automatic write_strip(bit v);
    cfg_valid_i = 1'b1;
    cfg_strip_mode_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.strip = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    do @(negedge clk_i); while (sb.expected_q.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic void add_item(logic [7:0] b, bit last);
    in_item_t it;
    it.in_byte = b;
    it.last_in = last;
    text_q.push_back(it);
  endfunction

  // random text, mostly well-formed escapes with random content
  function automatic void make_text();
    logic [7:0] raw[$];
    int         pieces;
    int         r;
    pieces = $urandom_range(6, 1);
    for (int k = 0; k < pieces; k++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        raw.push_back(TICK_CHAR);
        raw.push_back(esc_codes[$urandom_range(16)]);
      end else if (r < 48) begin
        raw.push_back(TICK_CHAR);
        raw.push_back("=");
      end else if (r < 60) begin
        raw.push_back(TICK_CHAR);
        raw.push_back("f");
        if ($urandom_range(3) == 0) raw.push_back(8'($urandom_range(255)));
        else raw.push_back(8'(48 + $urandom_range(9)));
      end else if (r < 68) begin
        raw.push_back(TICK_CHAR);
        raw.push_back(8'($urandom_range(255)));
      end else if (r < 72) begin
        raw.push_back(TICK_CHAR);
      end else begin
        raw.push_back(8'($urandom_range(255)));
      end
    end
    // sometimes end the text in the middle of an escape
    if (raw.size() > 1 && $urandom_range(9) == 0) void'(raw.pop_back());
    foreach (raw[i]) add_item(raw[i], i == raw.size() - 1);
  endfunction

  initial begin
    int sent;
    bit paused;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_strip_mode_i = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    hold_rx = 1'b0;
    cycles = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_strip(1'b0);
    add_item(8'h00, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(TICK_CHAR, 1'b0);
    add_item("=", 1'b0);
    add_item(TICK_CHAR, 1'b0);
    add_item("4", 1'b0);
    // unknown codes give a lone backtick
    add_item(TICK_CHAR, 1'b0);
    add_item("a", 1'b0);
    add_item(TICK_CHAR, 1'b0);
    add_item(8'h00, 1'b0);
    add_item(TICK_CHAR, 1'b0);
    add_item("f", 1'b0);
    add_item("9", 1'b0);
    // non-digit size falls back to 8
    add_item(TICK_CHAR, 1'b0);
    add_item("f", 1'b0);
    add_item("q", 1'b0);
    add_item(TICK_CHAR, 1'b0);
    add_item("^", 1'b1);
    // backtick alone on the last byte
    add_item(TICK_CHAR, 1'b1);
    // backtick and f with f on the last byte
    add_item(TICK_CHAR, 1'b0);
    add_item("f", 1'b1);
    add_item(TICK_CHAR, 1'b0);
    add_item("f", 1'b0);
    add_item("0", 1'b1);
    send_text();
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 64; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 64; end
        3: begin send_idle = 6;  recv_stall = 6;  end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      write_strip(p[0] ? 1'b0 : 1'b1);
      if (p == 4) begin
        fork
          begin
            @(posedge clk_i);
            hold_rx = 1'b1;
            repeat (RX_HOLD) @(posedge clk_i);
            hold_rx = 1'b0;
          end
        join_none
      end
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        make_text();
        sent += text_q.size();
        send_text();
        // let everything drain before carrying on
        if (p == 3 && !paused && sent >= PHASE_ITEMS / 2) begin
          in_valid_i = 1'b0;
          do @(negedge clk_i); while (sb.expected_q.size() != 0);
          paused = 1'b1;
        end
      end
      drain();
    end

    if (sb.errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule
